[rtl/keyed_write_buffer_table_macros.svh]
// Assertion macros shared by the RTL of the keyed write buffer table.
// Both sample on the rising edge of clock and are disabled while reset is high.
`ifndef KEYED_WRITE_BUFFER_TABLE_MACROS_SVH
`define KEYED_WRITE_BUFFER_TABLE_MACROS_SVH

// The condition holds at every edge.
`define KWBT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define KWBT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/kwbt_pkg.sv]
`default_nettype none

package kwbt_pkg;

   localparam int ENTRIES_DEFAULT    = 64;
   localparam int KEY_BITS_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int CFG_BITS   = 7;
   localparam int COUNT_BITS = 7;

   localparam logic [CFG_BITS-1:0]   CAPACITY_RESET = 7'd64;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX      = 7'd127;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_APPLY = 5'b00100,
      S_BOUND = 5'b01000,
      S_DONE  = 5'b10000
   } kwbt_state_type;

endpackage

`default_nettype wire

[rtl/kwbt_ram.sv]
`default_nettype none

module kwbt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/keyed_write_buffer_table.sv]
// Each item walks the stored entries in the key memory; a lookup that hits ends its walk early,
// and an insert that freezes the table adds a second pass over the entries for the key bounds.
// While a finished result is stalled, the next item waits in its done state.
// Throughput: one item at a time; one shared compare unit walks the key memory one entry per cycle.
// A finished result waits in an output register, so the next item can be taken meanwhile.
// Reset (synchronous, active high) empties the table, clears the counts, the freeze flag and
// the latched keys, and sets capacity to 64; stored keys and values are left as they are.
`default_nettype none
`include "keyed_write_buffer_table_macros.svh"

module keyed_write_buffer_table
   import kwbt_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEFAULT,
   parameter int KEY_BITS   = KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  csr_wr_en,
   input  wire logic [CFG_BITS-1:0]   csr_wr_data,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_accepted,
   output logic                       rsp_frozen,
   output logic      [KEY_BITS-1:0]   rsp_key_min,
   output logic      [KEY_BITS-1:0]   rsp_key_max,
   output logic      [COUNT_BITS-1:0] rsp_entries_used
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   kwbt_state_type state_ff, state_in;

   logic                  kind_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   logic [CNT_W-1:0]      issue_idx_ff, issue_idx_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic                  acc_ff, acc_in;

   logic [CNT_W-1:0]      fill_count_ff, fill_count_in;
   logic [COUNT_BITS-1:0] write_count_ff, write_count_in;
   logic                  freeze_ff, freeze_in;
   logic [KEY_BITS-1:0]   low_key_ff, low_key_in;
   logic [KEY_BITS-1:0]   high_key_ff, high_key_in;
   logic [CFG_BITS-1:0]   capacity_ff, capacity_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_accepted_ff;
   logic                  rsp_frozen_ff;
   logic [KEY_BITS-1:0]   rsp_key_min_ff;
   logic [KEY_BITS-1:0]   rsp_key_max_ff;
   logic [COUNT_BITS-1:0] rsp_entries_used_ff;

   logic                  req_fire;
   logic                  rsp_load;
   logic                  issue;
   logic                  scan_end;

   logic                  key_we;
   logic [IDX_W-1:0]      key_waddr;
   logic [KEY_BITS-1:0]   key_wdata;
   logic [KEY_BITS-1:0]   key_rdata;
   logic                  value_we;
   logic [IDX_W-1:0]      value_waddr;

   logic                  key_eq, key_lt, key_gt;
   logic [COUNT_BITS-1:0] write_count_inc;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // Shared compare unit on the key memory read port.
   assign key_eq = (key_rdata == key_ff);
   assign key_lt = (key_rdata < low_key_ff);
   assign key_gt = (key_rdata > high_key_ff);

   assign issue    = (state_ff inside {S_SCAN, S_BOUND})
                     && (issue_idx_ff < fill_count_ff);
   // The walk is over once every entry has been read and compared.
   assign scan_end = !pend_ff && (issue_idx_ff == fill_count_ff);
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign write_count_inc = (write_count_ff < COUNT_MAX) ? write_count_ff + 1'b1
                                                         : write_count_ff;

   always_comb begin
      state_in       = state_ff;
      issue_idx_in   = issue_idx_ff;
      pend_in        = issue;
      pend_idx_in    = issue_idx_ff[IDX_W-1:0];
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      acc_in         = acc_ff;
      fill_count_in  = fill_count_ff;
      write_count_in = write_count_ff;
      freeze_in      = freeze_ff;
      low_key_in     = low_key_ff;
      high_key_in    = high_key_ff;
      capacity_in    = csr_wr_en ? csr_wr_data : capacity_ff;
      key_we         = 1'b0;
      key_waddr      = fill_count_ff[IDX_W-1:0];
      key_wdata      = key_ff;
      value_we       = 1'b0;
      value_waddr    = fill_count_ff[IDX_W-1:0];

      if (issue) begin
         issue_idx_in = issue_idx_ff + 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               issue_idx_in = '0;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pend_ff && key_eq) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               state_in   = S_APPLY;
            end else if (scan_end) begin
               hit_in   = 1'b0;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            acc_in       = 1'b0;
            state_in     = S_DONE;
            issue_idx_in = '0;
            if (kind_ff == KIND_REMOVE) begin
               if (hit_ff) begin
                  key_we    = 1'b1;
                  key_waddr = hit_idx_ff;
                  key_wdata = '0;
                  acc_in    = 1'b1;
               end
            end else if (!freeze_ff) begin
               write_count_in = write_count_inc;
               if (hit_ff) begin
                  value_we    = 1'b1;
                  value_waddr = hit_idx_ff;
                  acc_in      = (write_count_inc < capacity_ff);
               end else if (fill_count_ff == FULL_COUNT) begin
                  state_in = S_BOUND;
               end else begin
                  key_we        = 1'b1;
                  value_we      = 1'b1;
                  fill_count_in = fill_count_ff + 1'b1;
                  if (write_count_inc >= capacity_ff) begin
                     state_in = S_BOUND;
                  end else begin
                     acc_in = 1'b1;
                  end
               end
            end
         end
         S_BOUND: begin
            // The first entry seeds both bounds; later entries only widen them.
            if (pend_ff) begin
               if (pend_idx_ff == '0) begin
                  low_key_in  = key_rdata;
                  high_key_in = key_rdata;
               end else begin
                  if (key_lt) begin
                     low_key_in = key_rdata;
                  end
                  if (key_gt) begin
                     high_key_in = key_rdata;
                  end
               end
            end else if (scan_end) begin
               freeze_in = 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         issue_idx_ff   <= '0;
         pend_ff        <= 1'b0;
         hit_ff         <= 1'b0;
         acc_ff         <= 1'b0;
         fill_count_ff  <= '0;
         write_count_ff <= '0;
         freeze_ff      <= 1'b0;
         low_key_ff     <= '0;
         high_key_ff    <= '0;
         capacity_ff    <= CAPACITY_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_idx_ff   <= issue_idx_in;
         pend_ff        <= pend_in;
         hit_ff         <= hit_in;
         acc_ff         <= acc_in;
         fill_count_ff  <= fill_count_in;
         write_count_ff <= write_count_in;
         freeze_ff      <= freeze_in;
         low_key_ff     <= low_key_in;
         high_key_ff    <= high_key_in;
         capacity_ff    <= capacity_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      hit_idx_ff  <= hit_idx_in;
      if (req_fire) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      // The result is a snapshot, so a stalled result survives the next item.
      if (rsp_load) begin
         rsp_accepted_ff     <= acc_ff;
         rsp_frozen_ff       <= freeze_ff;
         rsp_key_min_ff      <= low_key_ff;
         rsp_key_max_ff      <= high_key_ff;
         rsp_entries_used_ff <= COUNT_BITS'(fill_count_ff);
      end
   end

   kwbt_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_en   (issue),
      .rd_addr (issue_idx_ff[IDX_W-1:0]),
      .rd_data (key_rdata)
   );

   // Values are kept for the stored entries; no result field reads them back.
   kwbt_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (value_waddr),
      .wr_data (value_ff),
      .rd_en   (1'b0),
      .rd_addr ('0),
      .rd_data ()
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_frozen       = rsp_frozen_ff;
   assign rsp_key_min      = rsp_key_min_ff;
   assign rsp_key_max      = rsp_key_max_ff;
   assign rsp_entries_used = rsp_entries_used_ff;

   `KWBT_ASSERT_ALWAYS(a_fill_bound, fill_count_ff <= FULL_COUNT, "fill count beyond table")
   `KWBT_ASSERT_ALWAYS(a_issue_bound, issue_idx_ff <= fill_count_ff, "walk beyond fill count")
   `KWBT_ASSERT_NEXT(a_freeze_sticky, freeze_ff, freeze_ff, "table left the frozen state")
   `KWBT_ASSERT_NEXT(a_frozen_no_append, freeze_ff, $stable(fill_count_ff),
                     "entry appended after freeze")

endmodule

`default_nettype wire

[test/tb_keyed_write_buffer_table.sv]
`default_nettype none

module tb_keyed_write_buffer_table;
   timeunit 1ns;
   timeprecision 1ps;

   import kwbt_pkg::*;

   localparam int CLOCK_PERIOD   = 4;
   localparam int SLOTS          = ENTRIES_DEFAULT;
   localparam int KEY_W          = KEY_BITS_DEFAULT;
   localparam int VAL_W          = VALUE_BITS_DEFAULT;
   localparam int TOTAL_ITEMS    = 1350;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 2 * SLOTS + 16;
   localparam int BASE_GAP_PCT   = 18;

   typedef struct packed {
      logic                  accepted;
      logic                  frozen;
      logic [KEY_W-1:0]      key_min;
      logic [KEY_W-1:0]      key_max;
      logic [COUNT_BITS-1:0] used;
   } status_type;

   // One row of the directed table. Where typed is set, accepted and used are the
   // expected result, read straight off the behavior; the table is never frozen here.
   typedef struct packed {
      logic                  kind;
      logic [KEY_W-1:0]      key;
      logic [VAL_W-1:0]      value;
      logic                  typed;
      logic                  accepted;
      logic [COUNT_BITS-1:0] used;
   } vector_type;

   typedef enum {MIX_BUILD, MIX_CHURN, MIX_FROZEN} mix_type;

   localparam vector_type VECTORS [16] = '{
      '{KIND_REMOVE, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, 1'b0, 7'd0},
      '{KIND_INSERT, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, 1'b1, 7'd1},
      '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd2},
      '{KIND_INSERT, 64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 7'd2},
      '{KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 7'd2},
      '{KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 7'd2},
      '{KIND_REMOVE, 64'h0000_0000_0000_0000, 32'h0000_0000, 1'b1, 1'b1, 7'd2},
      '{KIND_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b1, 1'b1, 7'd3},
      '{KIND_INSERT, 64'h0000_0000_0000_0001, 32'h0000_0001, 1'b1, 1'b1, 7'd4},
      '{KIND_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 7'd5},
      '{KIND_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555, 1'b0, 1'b0, 7'd0},
      '{KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b0, 7'd0},
      '{KIND_REMOVE, 64'h0000_0000_0000_0001, 32'h0000_0000, 1'b0, 1'b0, 7'd0},
      '{KIND_INSERT, 64'h8000_0000_0000_0000, 32'h0000_0000, 1'b0, 1'b0, 7'd0},
      '{KIND_REMOVE, 64'h0000_0000_0000_1234, 32'h0000_0000, 1'b0, 1'b0, 7'd0},
      '{KIND_INSERT, 64'h0000_0000_0000_0000, 32'h0000_0001, 1'b0, 1'b0, 7'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CFG_BITS-1:0]   csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_INSERT;
   logic [KEY_W-1:0]      req_key = '0;
   logic [VAL_W-1:0]      req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_accepted;
   logic                  rsp_frozen;
   logic [KEY_W-1:0]      rsp_key_min;
   logic [KEY_W-1:0]      rsp_key_max;
   logic [COUNT_BITS-1:0] rsp_entries_used;

   // Shadow copy of the table.
   logic [KEY_W-1:0]    tbl_key [SLOTS];
   logic [VAL_W-1:0]    tbl_val [SLOTS];
   int                  n_fill = 0;
   int                  n_writes = 0;
   logic                is_frozen = 1'b0;
   logic [KEY_W-1:0]    lo_key = '0;
   logic [KEY_W-1:0]    hi_key = '0;
   logic [CFG_BITS-1:0] cap_reg = CAPACITY_RESET;

   status_type pending_status [$];
   int         mismatches = 0;
   int         items_sent = 0;
   int         results_seen = 0;
   int         quiet_cycles = 0;
   int         gap_pct = BASE_GAP_PCT;

   keyed_write_buffer_table dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_frozen       (rsp_frozen),
      .rsp_key_min      (rsp_key_min),
      .rsp_key_max      (rsp_key_max),
      .rsp_entries_used (rsp_entries_used)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < n_fill; i++) begin
         if (tbl_key[i] == k) return i;
      end
      return -1;
   endfunction

   function automatic int next_writes();
      return (n_writes < COUNT_MAX) ? n_writes + 1 : n_writes;
   endfunction

   function automatic void freeze_table();
      lo_key = (n_fill > 0) ? tbl_key[0] : '0;
      hi_key = lo_key;
      for (int i = 1; i < n_fill; i++) begin
         if (tbl_key[i] < lo_key) lo_key = tbl_key[i];
         if (tbl_key[i] > hi_key) hi_key = tbl_key[i];
      end
      is_frozen = 1'b1;
   endfunction

   // Applies one item to the shadow table and returns the status it should produce.
   function automatic status_type buffer_step(logic kind, logic [KEY_W-1:0] k,
                                              logic [VAL_W-1:0] v);
      status_type s;
      int         hit;
      hit = find_key(k);
      s.accepted = 1'b0;
      if (kind == KIND_REMOVE) begin
         if (hit >= 0) begin
            tbl_key[hit] = '0;
            s.accepted = 1'b1;
         end
      end else if (!is_frozen) begin
         n_writes = next_writes();
         if (hit >= 0) begin
            tbl_val[hit] = v;
            s.accepted = (n_writes < int'(cap_reg));
         end else if (n_fill >= SLOTS) begin
            // No slot left: the key is dropped and the table freezes as it is.
            freeze_table();
         end else begin
            tbl_key[n_fill] = k;
            tbl_val[n_fill] = v;
            n_fill++;
            if (n_writes >= int'(cap_reg)) freeze_table();
            else s.accepted = 1'b1;
         end
      end
      s.frozen  = is_frozen;
      s.key_min = lo_key;
      s.key_max = hi_key;
      s.used    = n_fill[COUNT_BITS-1:0];
      return s;
   endfunction

   function automatic logic [KEY_W-1:0] any_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {1'b1, {(KEY_W-1){1'b0}}};
         3: return KEY_W'($urandom_range(0, 15));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] held_key();
      if (n_fill == 0) return any_key();
      return tbl_key[$urandom_range(0, n_fill - 1)];
   endfunction

   // Picks a random item. Unless allowed, an insert that would freeze the table is turned into an
   // update of a held key, or into a remove when the table is empty, so the table stays open for later phases.
   task automatic pick_op(input mix_type mix, input bit allow_freeze, output logic kind,
                          output logic [KEY_W-1:0] k);
      int fresh_pct;
      int held_pct;
      int rm_held_pct;
      int roll;
      case (mix)
         MIX_BUILD: begin
            fresh_pct = 60; held_pct = 20; rm_held_pct = 10;
         end
         MIX_CHURN: begin
            fresh_pct = 15; held_pct = 55; rm_held_pct = 15;
         end
         default: begin
            fresh_pct = 20; held_pct = 15; rm_held_pct = 30;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < fresh_pct) begin
         kind = KIND_INSERT; k = any_key();
      end else if (roll < fresh_pct + held_pct) begin
         kind = KIND_INSERT; k = held_key();
      end else if (roll < fresh_pct + held_pct + rm_held_pct) begin
         kind = KIND_REMOVE; k = held_key();
      end else begin
         kind = KIND_REMOVE; k = any_key();
      end
      if (!allow_freeze && kind == KIND_INSERT && !is_frozen && find_key(k) < 0 &&
          (n_fill >= SLOTS || next_writes() >= int'(cap_reg))) begin
         if (n_fill > 0) k = tbl_key[$urandom_range(0, n_fill - 1)];
         else kind = KIND_REMOVE;
      end
   endtask

   task automatic send_op(input logic kind, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v, input bit typed,
                          input status_type typed_status);
      status_type s;
      gap_pct = (items_sent inside {[250:449]}) ? 0 : BASE_GAP_PCT;
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_key   <= k;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      s = buffer_step(kind, k, v);
      pending_status = {pending_status, (typed ? typed_status : s)};
      items_sent++;
   endtask

   task automatic run_random(input mix_type mix, input int count);
      logic             kind;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         pick_op(mix, 1'b0, kind, k);
         send_op(kind, k, $urandom, 1'b0, '0);
      end
   endtask

   // The register is only written once every outstanding result has come back.
   task automatic set_capacity(input logic [CFG_BITS-1:0] v);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_reg = v;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < gap_pct);
   end

   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_status.size() == 0) begin
            $error("result with no item outstanding");
            mismatches++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_accepted);
               mismatches++;
            end
            if (rsp_frozen !== want.frozen) begin
               $error("frozen: expected %0d, got %0d", want.frozen, rsp_frozen);
               mismatches++;
            end
            if (rsp_key_min !== want.key_min) begin
               $error("key_min: expected %h, got %h", want.key_min, rsp_key_min);
               mismatches++;
            end
            if (rsp_key_max !== want.key_max) begin
               $error("key_max: expected %h, got %h", want.key_max, rsp_key_max);
               mismatches++;
            end
            if (rsp_entries_used !== want.used) begin
               $error("entries_used: expected %0d, got %0d", want.used, rsp_entries_used);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles.", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      status_type          typed_status;
      logic                kind;
      logic [KEY_W-1:0]    k;
      logic [CFG_BITS-1:0] churn_caps [5];
      int                  fill_target;
      int                  built;
      string               freeze_path;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset capacity.
      foreach (VECTORS[i]) begin
         typed_status.accepted = VECTORS[i].accepted;
         typed_status.frozen   = 1'b0;
         typed_status.key_min  = '0;
         typed_status.key_max  = '0;
         typed_status.used     = VECTORS[i].used;
         send_op(VECTORS[i].kind, VECTORS[i].key, VECTORS[i].value, VECTORS[i].typed,
                 typed_status);
      end

      // Fill the table, either completely or up to a random level, without freezing.
      set_capacity(COUNT_MAX);
      fill_target = $urandom_range(0, 1) ? SLOTS : $urandom_range(6, SLOTS - 4);
      built = 0;
      while (n_fill < fill_target && built < 400) begin
         pick_op(MIX_BUILD, 1'b0, kind, k);
         send_op(kind, k, $urandom, 1'b0, '0);
         built++;
      end

      // Updates and removes under several capacities; this also saturates the write count.
      churn_caps[0] = '0;
      churn_caps[1] = CFG_BITS'(1);
      churn_caps[2] = COUNT_MAX;
      churn_caps[3] = CAPACITY_RESET;
      churn_caps[4] = CFG_BITS'($urandom_range(2, 126));
      foreach (churn_caps[i]) begin
         set_capacity(churn_caps[i]);
         run_random(MIX_CHURN, 90);
      end

      // Freeze with a key that is surely new: a full table drops it, otherwise the
      // capacity is set low enough that appending it freezes the table.
      if (n_fill >= SLOTS) begin
         freeze_path = "on a full table";
         set_capacity(CFG_BITS'($urandom_range(0, COUNT_MAX)));
      end else begin
         freeze_path = "by reaching capacity";
         set_capacity($urandom_range(0, 1) ? '0 : CFG_BITS'($urandom_range(0, next_writes())));
      end
      do k = {$urandom, $urandom}; while (find_key(k) >= 0);
      send_op(KIND_INSERT, k, $urandom, 1'b0, '0);
      send_op(KIND_INSERT, held_key(), $urandom, 1'b0, '0);
      send_op(KIND_REMOVE, '0, $urandom, 1'b0, '0);

      // A frozen table still serves removes; the register no longer matters.
      run_random(MIX_FROZEN, 400);
      set_capacity(CFG_BITS'($urandom_range(0, COUNT_MAX)));
      while (items_sent < TOTAL_ITEMS) begin
         pick_op(MIX_FROZEN, 1'b1, kind, k);
         send_op(kind, k, $urandom, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d directed), checked %0d results across capacities 0 to %0d.",
               items_sent, $size(VECTORS), results_seen, COUNT_MAX);
      $display("The table froze %s holding %0d entries; write count ended at %0d.",
               freeze_path, n_fill, n_writes);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
